// ===== rtl/frasm_pkg.sv =====
// Shared types and constants for the fragment reassembler.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package frasm_pkg;

    localparam int DEFAULT_BUFFER_BYTES = 4096;
    localparam int LEN_W                = 13;
    localparam int POSITION_MAX         = 8191;
    localparam int HEADER_LEN           = 6;
    localparam int OPCODE_LEN           = 2;

    localparam logic [LEN_W-1:0] MAX_MSG_RESET = 13'd4096;

    // Command carried in s_tuser.
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Result kind carried in m_tuser.
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] opcode;
        logic [11:0] length;
        logic [15:0] number;
        logic        rd_hit;
    } frasm_res_t;

endpackage

// ===== rtl/frasm_buffer.sv =====
// Message buffer: one write port and one registered read port.
// Depends on frasm_pkg only for the default depth.
`timescale 1ns / 1ps

module frasm_buffer #(
    parameter int BUFFER_BYTES = frasm_pkg::DEFAULT_BUFFER_BYTES,
    parameter int ADDR_W       = $clog2(BUFFER_BYTES)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    import frasm_pkg::*;

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/frasm_ctrl.sv =====
// Frame parser and message state: header capture, fragment checks, buffer
// addressing and completion reports. Depends on frasm_pkg.
`timescale 1ns / 1ps

module frasm_ctrl #(
    parameter int BUFFER_BYTES = frasm_pkg::DEFAULT_BUFFER_BYTES,
    parameter int ADDR_W       = $clog2(BUFFER_BYTES)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [frasm_pkg::LEN_W-1:0] cfg_value,
    input  logic                     accept,
    input  logic                     command,
    input  logic [7:0]               frame_byte,
    input  logic                     frame_end,
    input  logic                     frame_bad,
    input  logic [11:0]              read_offset,
    output logic                     wr_en,
    output logic [ADDR_W-1:0]        wr_addr,
    output logic [7:0]               wr_data,
    output logic                     rd_en,
    output logic [ADDR_W-1:0]        rd_addr,
    output logic                     res_valid,
    output frasm_pkg::frasm_res_t    res
);

    import frasm_pkg::*;

    localparam int BUF_CAP = (BUFFER_BYTES > POSITION_MAX) ? POSITION_MAX : BUFFER_BYTES;

    logic [LEN_W-1:0] max_bytes_reg;
    logic [47:0]      header_reg, header_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic             ovf_reg, ovf_next;
    logic [15:0]      id_reg, id_next;
    logic [15:0]      exp_reg, exp_next;
    logic [15:0]      total_reg, total_next;
    logic [LEN_W-1:0] stored_reg, stored_next;
    logic [7:0]       op_lo_reg, op_lo_next;
    logic [7:0]       op_hi_reg, op_hi_next;

    logic [LEN_W-1:0] limit;
    logic [LEN_W:0]   pay_addr;
    logic [LEN_W-1:0] pos_inc;
    logic             ovf_w;
    logic [LEN_W-1:0] stored_w;
    logic [47:0]      header_w;
    logic [15:0]      h_id, h_idx, h_cnt, idx_inc;
    logic [LEN_W-1:0] base_len;
    logic [LEN_W:0]   msg_len;
    logic [LEN_W-1:0] rd_byte;

    assign limit = (max_bytes_reg > LEN_W'(BUF_CAP)) ? LEN_W'(BUF_CAP) : max_bytes_reg;
    assign pay_addr = {1'b0, stored_reg} + {1'b0, pos_reg} - (LEN_W+1)'(HEADER_LEN);
    assign rd_byte  = LEN_W'(read_offset) + LEN_W'(OPCODE_LEN);

    // Header as it stands once the current byte is in.
    assign header_w = (pos_reg < LEN_W'(HEADER_LEN))
                    ? header_reg | (48'(frame_byte) << {pos_reg[2:0], 3'b000})
                    : header_reg;

    assign h_id    = header_w[15:0];
    assign h_idx   = header_w[31:16];
    assign h_cnt   = header_w[47:32];
    assign idx_inc = h_idx + 16'd1;

    always_comb begin
        header_next = header_reg;
        pos_next    = pos_reg;
        ovf_next    = ovf_reg;
        id_next     = id_reg;
        exp_next    = exp_reg;
        total_next  = total_reg;
        stored_next = stored_reg;
        op_lo_next  = op_lo_reg;
        op_hi_next  = op_hi_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        res_valid   = 1'b0;
        pos_inc     = pos_reg;
        ovf_w       = ovf_reg;
        stored_w    = stored_reg;
        base_len    = stored_reg;
        msg_len     = '0;

        res.kind   = KIND_DONE;
        res.opcode = {op_hi_reg, op_lo_reg};
        res.length = '0;
        res.number = id_reg;
        res.rd_hit = 1'b0;

        if (accept && command == CMD_READ) begin
            rd_en      = 1'b1;
            res_valid  = 1'b1;
            res.kind   = KIND_READ;
            res.opcode = '0;
            res.number = '0;
            res.rd_hit = rd_byte < stored_reg;
        end else if (accept) begin
            ovf_w = ovf_reg | frame_bad;
            if (pos_reg < LEN_W'(HEADER_LEN)) begin
                header_next = header_w;
                // The index is complete once its high byte is in.
                if (pos_reg == LEN_W'(HEADER_LEN - 1) && header_reg[31:16] == 16'd0) begin
                    stored_w = '0;
                end
            end else begin
                if (pay_addr >= {1'b0, limit}) begin
                    ovf_w = 1'b1;
                end else if (!ovf_w) begin
                    wr_en = 1'b1;
                    if (pay_addr == '0) begin
                        op_lo_next = frame_byte;
                    end
                    if (pay_addr == (LEN_W+1)'(1)) begin
                        op_hi_next = frame_byte;
                    end
                end
            end
            if (pos_reg < LEN_W'(POSITION_MAX)) begin
                pos_inc = pos_reg + LEN_W'(1);
            end else begin
                ovf_w = 1'b1;
            end
            pos_next    = pos_inc;
            ovf_next    = ovf_w;
            stored_next = stored_w;

            if (frame_end) begin
                header_next = '0;
                pos_next    = '0;
                ovf_next    = 1'b0;
                base_len    = (h_idx == 16'd0) ? LEN_W'(0) : stored_w;
                msg_len     = {1'b0, base_len} + {1'b0, pos_inc} - (LEN_W+1)'(HEADER_LEN);
                if (ovf_w || pos_inc < LEN_W'(HEADER_LEN) || h_idx == 16'd0 && h_cnt == 16'd0
                    || h_idx != 16'd0 && (total_reg == 16'd0 || h_id != id_reg
                    || h_idx != exp_reg || h_cnt != total_reg)) begin
                    id_next     = '0;
                    exp_next    = '0;
                    total_next  = '0;
                    stored_next = '0;
                end else if (idx_inc < h_cnt) begin
                    id_next     = h_id;
                    total_next  = h_cnt;
                    exp_next    = idx_inc;
                    stored_next = msg_len[LEN_W-1:0];
                end else if (msg_len < (LEN_W+1)'(OPCODE_LEN)) begin
                    id_next     = '0;
                    exp_next    = '0;
                    total_next  = '0;
                    stored_next = '0;
                end else begin
                    // The message is complete; its payload stays readable.
                    res_valid   = 1'b1;
                    res.opcode  = {op_hi_next, op_lo_next};
                    res.length  = 12'(msg_len - (LEN_W+1)'(OPCODE_LEN));
                    res.number  = h_id;
                    id_next     = '0;
                    exp_next    = '0;
                    total_next  = '0;
                    stored_next = msg_len[LEN_W-1:0];
                end
            end
        end
    end

    assign wr_addr = ADDR_W'(pay_addr);
    assign wr_data = frame_byte;
    assign rd_addr = ADDR_W'(rd_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_MSG_RESET;
            header_reg    <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            id_reg        <= '0;
            exp_reg       <= '0;
            total_reg     <= '0;
            stored_reg    <= '0;
        end else begin
            if (cfg_we) begin
                max_bytes_reg <= cfg_value;
            end
            header_reg <= header_next;
            pos_reg    <= pos_next;
            ovf_reg    <= ovf_next;
            id_reg     <= id_next;
            exp_reg    <= exp_next;
            total_reg  <= total_next;
            stored_reg <= stored_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_lo_reg <= op_lo_next;
        op_hi_reg <= op_hi_next;
    end

endmodule

// ===== rtl/frasm_out.sv =====
// Result path: a stage that waits for the buffer read data, then the output
// register that drives the master side. Depends on frasm_pkg.
`timescale 1ns / 1ps

module frasm_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  res_valid,
    input  frasm_pkg::frasm_res_t res,
    input  logic [7:0]            rd_data,
    output logic                  in_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,
    output logic                  m_tuser
);

    import frasm_pkg::*;

    logic       st_valid_reg, st_valid_next;
    frasm_res_t st_reg;
    logic       out_valid_reg, out_valid_next;
    logic [55:0] out_data_reg;
    logic        out_user_reg;
    logic        advance;
    logic [7:0]  byte_out;

    // The stage moves on whenever the output register is free or being emptied.
    assign advance  = st_valid_reg && (!out_valid_reg || m_tready);
    assign in_ready = !st_valid_reg || advance;
    assign byte_out = st_reg.rd_hit ? rd_data : 8'd0;

    always_comb begin
        st_valid_next = st_valid_reg;
        if (accept) begin
            st_valid_next = res_valid;
        end else if (advance) begin
            st_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_reg <= res;
        end
        if (advance) begin
            out_data_reg <= {4'd0, byte_out, st_reg.number, st_reg.length, st_reg.opcode};
            out_user_reg <= st_reg.kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/fragment_reassembler.sv =====
// Top level of the fragment reassembler: parser, message buffer, result path.
// Depends on frasm_pkg, frasm_ctrl, frasm_buffer and frasm_out.
`timescale 1ns / 1ps

// The block takes one word per cycle on the slave side, frame bytes and read
// commands alike, and holds at most one word of work in flight beyond the
// output register. Every frame byte makes at most one write to the message
// buffer; a read command makes one read of the buffer, whose registered data
// passes through the result stage and the output register to the master
// side, as does a completion report. While the master side keeps up, the
// slave side never stalls. A message holds at most max_message_bytes bytes,
// opcode included, and never more than BUFFER_BYTES. Completion reports come
// out on the last byte of the last fragment; the payload of that message
// stays readable until the next index-0 header or the next failure. The
// buffer needs no clearing after reset.
module fragment_reassembler #(
    parameter int BUFFER_BYTES = frasm_pkg::DEFAULT_BUFFER_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [frasm_pkg::LEN_W-1:0] cfg_data,   // max_message_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // frame_byte[7:0], frame_bad[8], read_offset[20:9]
    input  logic        s_tlast,   // frame_end
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // message_opcode[15:0], payload_length[27:16],
                                   // message_number[43:28], read_data[51:44]
    output logic        m_tuser    // result_kind
);

    import frasm_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);

    logic              accept;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data;
    logic              res_valid;
    frasm_res_t        res;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    frasm_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_value   (cfg_data),
        .accept      (accept),
        .command     (s_tuser),
        .frame_byte  (s_tdata[7:0]),
        .frame_end   (s_tlast),
        .frame_bad   (s_tdata[8]),
        .read_offset (s_tdata[20:9]),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .res_valid   (res_valid),
        .res         (res)
    );

    frasm_buffer #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    frasm_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .res_valid (res_valid),
        .res       (res),
        .rd_data   (rd_data),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
